FILE: rtl/core/stms_pkg.sv
`default_nettype none
package stms_pkg;

   localparam int MaxGroupsDefault = 64;
   localparam logic [15:0] Ln2Q16 = 16'd45426;

   typedef enum logic [1:0] {
      KIND_LOAD  = 2'd0,
      KIND_SCORE = 2'd1,
      KIND_CLEAR = 2'd2,
      KIND_NONE  = 2'd3
   } kind_type;

   function automatic logic [15:0] log_rom(input logic [7:0] k);
      logic [63:0] v;
      logic [15:0] bits;
      v = 64'(({1'b0, k} + 9'd256)) << 23;
      bits = '0;
      for (int b = 0; b < 16; b++) begin
         v = (v * v) >> 31;
         bits = bits << 1;
         if (v >= 64'h1_0000_0000) begin
            bits[0] = 1'b1;
            v = v >> 1;
         end
      end
      return bits;
   endfunction

   function automatic logic [255:0][15:0] log_table();
      logic [255:0][15:0] t;
      for (int k = 0; k < 256; k++) t[k] = log_rom(8'(k));
      return t;
   endfunction

   // log2 fraction of (1 + k/256), 16 fraction bits
   localparam logic [255:0][15:0] LogTable = log_table();

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return v[31:0];
   endfunction

endpackage
`default_nettype wire

FILE: rtl/core/stms_ram.sv
`default_nettype none
module stms_ram #(
   parameter int Width = 32,
   parameter int Depth = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

FILE: rtl/core/stms_score.sv
`default_nettype none
// Pipelined score datapath: 7 register stages.
module stms_score import stms_pkg::*; #(
   parameter int GrpWidth = 6
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   input  wire logic [GrpWidth-1:0] in_grp,
   input  wire logic                in_last,
   input  wire logic signed [31:0]  in_sample,
   input  wire logic signed [31:0]  in_mean,
   input  wire logic [30:0]         in_prec,
   input  wire logic signed [31:0]  in_base,
   input  wire logic signed [31:0]  in_coeff,
   output logic                     out_valid,
   output logic [GrpWidth-1:0]      out_grp,
   output logic                     out_last,
   output logic signed [31:0]       out_s
);
   logic [6:0] v_ff;
   logic [GrpWidth-1:0] g_ff [7];
   logic [6:0] l_ff;
   logic signed [31:0] b_ff [7];
   logic signed [31:0] c_ff [7];
   logic [30:0] p_ff [2];

   logic [32:0] ad_ff;
   logic [31:0] q_ff, a_ff;
   logic [4:0]  ip_ff;
   logic [15:0] f_ff;
   logic [31:0] lg_ff, ln_ff;
   logic signed [31:0] s_ff;

   logic signed [32:0] d_in;
   logic [65:0] sq_in;
   logic [62:0] pq_in;
   logic [31:0] a_in;
   logic [4:0]  pos_in;
   logic [31:0] norm_in;
   logic [15:0] lo_in, hi_in, frac_in;
   logic [7:0]  k_in, r_in;
   logic [47:0] lnp_in;
   logic signed [63:0] tp_in;
   logic signed [63:0] term_in;
   logic signed [31:0] t32_in;

   always_comb begin
      d_in = 33'(in_sample) - 33'(in_mean);
      sq_in = 66'(ad_ff) * 66'(ad_ff);
      pq_in = 63'(p_ff[1]) * 63'(q_ff);
      if (pq_in[62:16] > 47'h7FFF_FFFF) a_in = 32'h7FFF_FFFF;
      else a_in = 32'(pq_in[47:16]) + 32'h10000;
      if (a_in > 32'h7FFF_FFFF) a_in = 32'h7FFF_FFFF;
      pos_in = 5'd16;
      for (int i = 17; i <= 30; i++) if (a_ff[i]) pos_in = 5'(i);
      norm_in = (a_ff - (32'd1 << pos_in)) >> (pos_in - 5'd16);
      k_in = f_ff[15:8];
      r_in = f_ff[7:0];
      lo_in = LogTable[k_in];
      hi_in = LogTable[k_in + 8'd1];
      if (k_in == 8'hFF) frac_in = 16'(lo_in + 16'(((17'h10000 - 17'(lo_in)) * 25'(r_in)) >> 8));
      else if (hi_in >= lo_in) frac_in = lo_in + 16'((24'(hi_in - lo_in) * 24'(r_in)) >> 8);
      else frac_in = lo_in - 16'((24'(lo_in - hi_in) * 24'(r_in) + 24'd255) >> 8);
      lnp_in = 48'(lg_ff) * 48'(Ln2Q16);
      tp_in = 64'(c_ff[5]) * $signed({1'b0, 63'(ln_ff)});
      term_in = tp_in >>> 16;
      t32_in = sat32(term_in);
   end

   always_ff @(posedge clock) begin
      if (reset) v_ff <= '0;
      else v_ff <= {v_ff[5:0], in_valid};
      g_ff[0] <= in_grp; l_ff[0] <= in_last; b_ff[0] <= in_base; c_ff[0] <= in_coeff;
      for (int i = 1; i < 7; i++) begin
         g_ff[i] <= g_ff[i-1]; l_ff[i] <= l_ff[i-1];
         b_ff[i] <= b_ff[i-1]; c_ff[i] <= c_ff[i-1];
      end
      p_ff[0] <= in_prec; p_ff[1] <= p_ff[0];
      ad_ff <= d_in[32] ? 33'(-d_in) : 33'(d_in);
      q_ff <= (sq_in[65:16] > 50'h7FFF_FFFF) ? 32'h7FFF_FFFF : sq_in[47:16];
      a_ff <= a_in;
      ip_ff <= pos_in - 5'd16;
      f_ff <= norm_in[15:0];
      lg_ff <= {16'(ip_ff), frac_in};
      ln_ff <= 32'(lnp_in >> 16);
      s_ff <= sat32(64'(b_ff[5]) + 64'(t32_in));
   end

   assign out_valid = v_ff[6];
   assign out_grp = g_ff[6];
   assign out_last = l_ff[6];
   assign out_s = s_ff;
endmodule
`default_nettype wire

FILE: rtl/core/stms_cell.sv
`default_nettype none
// One accumulator cell; a clear word zeroes it and a score result for its own group updates it.
// hit_acc carries the updated sum while this cell is hit, else zero.
module stms_cell import stms_pkg::*; #(
   parameter int Index = 0
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               clear,
   input  wire logic               upd,
   input  wire logic [9:0]         upd_grp,
   input  wire logic signed [31:0] upd_s,
   output logic signed [31:0]      hit_acc
);
   logic signed [31:0] acc_ff;
   logic hit;
   logic signed [31:0] sum;
   assign hit = upd && upd_grp == 10'(Index);
   assign sum = sat32(64'(acc_ff) + 64'(upd_s));
   always_ff @(posedge clock) begin
      if (reset || clear) acc_ff <= '0;
      else if (hit) acc_ff <= sum;
   end
   assign hit_acc = hit ? sum : '0;
endmodule
`default_nettype wire

FILE: rtl/core/student_t_mixture_scorer_unit.sv
`default_nettype none
// Score word: N = min(active_groups, MAX_GROUPS) results, one group per cycle
// while the output queue has room. The next word is taken when all N results
// are out. Load and clear words leave the unit idle. Synchronous active-high reset
// clears accumulators and sets active_groups to 1; parameter tables are undefined.
module student_t_mixture_scorer_unit import stms_pkg::*; #(
   parameter int MAX_GROUPS = MaxGroupsDefault
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [1:0]         req_kind,
   input  wire logic [5:0]         req_group_index,
   input  wire logic signed [31:0] req_sample,
   input  wire logic signed [31:0] req_group_mean,
   input  wire logic [30:0]        req_group_precision,
   input  wire logic signed [31:0] req_base_score,
   input  wire logic signed [31:0] req_log_coefficient,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [5:0]              rsp_out_group,
   output logic signed [31:0]      rsp_accumulated_score,
   output logic                    rsp_last,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [6:0]         csr_active_groups
);
   localparam int AW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
   localparam int CW = $clog2(MAX_GROUPS + 1);
   localparam int FifoDepth = 16;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001, ST_ISSUE = 3'b010, ST_DRAIN = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic [6:0] active_ff;
   logic [CW-1:0] n_ff, cnt_ff;
   logic signed [31:0] sample_ff;
   logic rd_v_ff, rd_last_ff;
   logic [AW-1:0] rd_g_ff;
   logic [127:0] rd_data, wr_data;
   logic [AW-1:0] wr_addr;
   logic acc_w, clr;
   logic [CW-1:0] n_in;

   logic s_valid, s_last;
   logic [AW-1:0] s_grp;
   logic signed [31:0] s_s;
   logic signed [31:0] sums [MAX_GROUPS];
   logic signed [31:0] hit_sum;

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign acc_w = req_valid && req_ready;
   assign clr = acc_w && req_kind == KIND_CLEAR;
   assign wr_addr = AW'(req_group_index);
   assign wr_data = {req_group_mean, 1'b0, req_group_precision, req_base_score,
                     req_log_coefficient};
   assign n_in = (32'(active_ff) > 32'(MAX_GROUPS)) ? CW'(MAX_GROUPS) : CW'(active_ff);

   stms_ram #(.Width(128), .Depth(MAX_GROUPS)) u_ram (
      .clock, .wr_en(acc_w && req_kind == KIND_LOAD &&
                     32'(req_group_index) < 32'(MAX_GROUPS)),
      .wr_addr, .wr_data, .rd_addr(cnt_ff[AW-1:0]), .rd_data);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (acc_w && req_kind == KIND_SCORE && n_in != '0) state_in = ST_ISSUE;
         ST_ISSUE: if (cnt_ff == n_ff - CW'(1)) state_in = ST_DRAIN;
         ST_DRAIN: if (rsp_valid && rsp_ready && rsp_last) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Results go straight to the cells and into an output queue deep enough for
   // all in-flight words; issue throttles on queue room.
   logic [FifoDepth-1:0][38:0] q_ff;
   logic [4:0] qc_ff;
   logic [3:0] qw_ff, qr_ff;
   logic issue, pop;
   logic [4:0] infl;
   always_ff @(posedge clock) begin
      if (reset) infl <= '0;
      else infl <= 5'(32'(infl) + (issue ? 1 : 0) - (s_valid ? 1 : 0));
   end
   assign issue = state_ff == ST_ISSUE && (32'(qc_ff) + 32'(infl) < FifoDepth - 1);
   assign pop = rsp_valid && rsp_ready;

   always_comb begin
      hit_sum = '0;
      for (int g = 0; g < MAX_GROUPS; g++) hit_sum = hit_sum | sums[g];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; active_ff <= 7'd1; cnt_ff <= '0; rd_v_ff <= 1'b0;
         qc_ff <= '0; qw_ff <= '0; qr_ff <= '0;
      end else begin
         state_ff <= (state_ff == ST_ISSUE && !issue) ? ST_ISSUE : state_in;
         if (csr_valid) active_ff <= csr_active_groups;
         if (state_ff == ST_IDLE) cnt_ff <= '0;
         else if (issue) cnt_ff <= cnt_ff + CW'(1);
         rd_v_ff <= issue;
         if (s_valid) begin
            q_ff[qw_ff] <= {6'(s_grp), s_last, hit_sum};
            qw_ff <= qw_ff + 4'd1;
         end
         if (pop) qr_ff <= qr_ff + 4'd1;
         qc_ff <= 5'(32'(qc_ff) + (s_valid ? 1 : 0) - (pop ? 1 : 0));
      end
      if (acc_w) begin n_ff <= n_in; sample_ff <= req_sample; end
      rd_g_ff <= cnt_ff[AW-1:0];
      rd_last_ff <= cnt_ff == n_ff - CW'(1);
   end

   stms_score #(.GrpWidth(AW)) u_score (
      .clock, .reset, .in_valid(rd_v_ff), .in_grp(rd_g_ff), .in_last(rd_last_ff),
      .in_sample(sample_ff), .in_mean(rd_data[127:96]), .in_prec(rd_data[94:64]),
      .in_base(rd_data[63:32]), .in_coeff(rd_data[31:0]),
      .out_valid(s_valid), .out_grp(s_grp), .out_last(s_last), .out_s(s_s));

   for (genvar g = 0; g < MAX_GROUPS; g++) begin : g_cell
      stms_cell #(.Index(g)) u_cell (
         .clock, .reset, .clear(clr), .upd(s_valid), .upd_grp(10'(s_grp)),
         .upd_s(s_s), .hit_acc(sums[g]));
   end

   assign rsp_valid = qc_ff != '0;
   assign rsp_out_group = q_ff[qr_ff][38:33];
   assign rsp_last = q_ff[qr_ff][32];
   assign rsp_accumulated_score = q_ff[qr_ff][31:0];

`ifndef SYNTHESIS
   a_fifo: assert property (@(posedge clock) disable iff (reset) 32'(qc_ff) <= FifoDepth)
      else $error("queue overflow");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> !req_ready) else $error("ready while busy");
   a_cnt: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ISSUE |-> cnt_ff < n_ff) else $error("issue count");
`endif
endmodule
`default_nettype wire

FILE: tb/tb_student_t_mixture_scorer_unit.sv
`timescale 1ns / 1ps
module tb_student_t_mixture_scorer_unit;
   import stms_pkg::*;

   typedef struct {
      kind_type          kind;
      logic [5:0]        grp;
      logic signed [31:0] sample;
      logic signed [31:0] mean;
      logic [30:0]       prec;
      logic signed [31:0] base;
      logic signed [31:0] coeff;
      bit                typed;
      logic signed [31:0] want;
   } word_type;

   typedef struct {
      logic [5:0]        grp;
      logic signed [31:0] score;
      logic              last;
   } score_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0] req_kind = '0;
   logic [5:0] req_group_index = '0;
   logic signed [31:0] req_sample = '0;
   logic signed [31:0] req_group_mean = '0;
   logic [30:0] req_group_precision = '0;
   logic signed [31:0] req_base_score = '0;
   logic signed [31:0] req_log_coefficient = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [5:0] rsp_out_group;
   logic signed [31:0] rsp_accumulated_score;
   logic rsp_last;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [6:0] csr_active_groups = 7'd1;

   student_t_mixture_scorer_unit u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_kind(req_kind),
      .req_group_index(req_group_index), .req_sample(req_sample),
      .req_group_mean(req_group_mean), .req_group_precision(req_group_precision),
      .req_base_score(req_base_score), .req_log_coefficient(req_log_coefficient),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_out_group(rsp_out_group),
      .rsp_accumulated_score(rsp_accumulated_score), .rsp_last(rsp_last),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_active_groups(csr_active_groups)
   );

   always #4 clock = ~clock;

   // predictor state
   logic signed [31:0] g_mean [64];
   logic [30:0]        g_prec [64];
   logic signed [31:0] g_base [64];
   logic signed [31:0] g_coeff [64];
   logic signed [31:0] g_acc [64];
   bit                 g_loaded [64];
   logic [6:0]         n_active;
   logic [15:0]        log2_frac [256];

   score_type pending_scores [$];
   int errors = 0;
   int stall_pct = 0;
   logic hold_req = 1'b0;

   task automatic report_mismatch(string what, longint exp_v, longint got_v);
      $display("[%0t] mismatch %s: expected %0d got %0d", $realtime, what, exp_v, got_v);
      errors++;
   endtask

   function automatic logic [15:0] frac_log2_entry(int k);
      longint unsigned v;
      logic [15:0] bits;
      v = longint'(256 + k) << 23;
      bits = '0;
      for (int b = 0; b < 16; b++) begin
         v = (v * v) >> 31;
         bits = bits << 1;
         if (v >= 64'h1_0000_0000) begin
            bits[0] = 1'b1;
            v = v >> 1;
         end
      end
      return bits;
   endfunction

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint unsigned ln_fixed(longint unsigned a);
      int p;
      longint unsigned f, lo, hi, frac, lg;
      int k, r;
      p = 30;
      while (p > 16 && !a[p]) p--;
      f = (a - (64'd1 << p)) >> (p - 16);
      k = int'((f >> 8) & 255);
      r = int'(f & 255);
      lo = log2_frac[k];
      hi = (k == 255) ? 64'd65536 : longint'(log2_frac[k + 1]);
      frac = (hi >= lo) ? lo + (((hi - lo) * r) >> 8) : lo - (((lo - hi) * r + 255) >> 8);
      lg = (longint'(p - 16) << 16) + frac;
      return (lg * 45426) >> 16;
   endfunction

   function automatic logic signed [31:0] group_score(int i, logic signed [31:0] x);
      longint d, term, s;
      longint unsigned ad, q, t, a, ln;
      d = longint'(x) - longint'(g_mean[i]);
      ad = (d < 0) ? -d : d;
      q = (ad * ad) >> 16;
      if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
      t = (longint'(g_prec[i]) * q) >> 16;
      if (t > 64'h7FFF_FFFF) t = 64'h7FFF_FFFF;
      a = t + 65536;
      if (a > 64'h7FFF_FFFF) a = 64'h7FFF_FFFF;
      ln = ln_fixed(a);
      term = clamp32((longint'(g_coeff[i]) * longint'(ln)) >>> 16);
      s = clamp32(longint'(g_base[i]) + term);
      return 32'(clamp32(longint'(g_acc[i]) + s));
   endfunction

   task automatic apply_word(word_type w);
      int n;
      score_type e;
      case (w.kind)
         KIND_LOAD: begin
            g_mean[w.grp] = w.mean;
            g_prec[w.grp] = w.prec;
            g_base[w.grp] = w.base;
            g_coeff[w.grp] = w.coeff;
            g_loaded[w.grp] = 1'b1;
         end
         KIND_CLEAR: foreach (g_acc[i]) g_acc[i] = '0;
         KIND_SCORE: begin
            n = (n_active > 64) ? 64 : n_active;
            for (int i = 0; i < n; i++) begin
               g_acc[i] = group_score(i, w.sample);
               e.grp = 6'(i);
               e.score = w.typed ? w.want : g_acc[i];
               e.last = (i == n - 1);
               pending_scores.push_back(e);
            end
         end
         default: ;
      endcase
   endtask

   int idle_pct = 0;

   task automatic send_word(word_type w);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= w.kind;
      req_group_index <= w.grp;
      req_sample <= w.sample;
      req_group_mean <= w.mean;
      req_group_precision <= w.prec;
      req_base_score <= w.base;
      req_log_coefficient <= w.coeff;
      do @(posedge clock); while (!req_ready);
      apply_word(w);
   endtask

   task automatic drain();
      while (pending_scores.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_csr(logic [6:0] v);
      csr_valid <= 1'b1;
      csr_active_groups <= v;
      do @(posedge clock); while (!csr_ready);
      n_active = v;
      csr_valid <= 1'b0;
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(5))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'($urandom_range(32'h3FFFF)) - 32'h20000;
         3: return 32'($urandom_range(32'h3FFFFF)) - 32'h200000;
         default: return $urandom;
      endcase
   endfunction

   // receiver
   int hold_left = 0;
   bit hold_done = 0;
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (hold_req && !hold_done) begin
         hold_done = 1;
         hold_left = 400;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      score_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_scores.size() == 0) begin
            report_mismatch("unexpected word, group", -1, rsp_out_group);
         end else begin
            e = pending_scores.pop_front();
            if (rsp_out_group !== e.grp) report_mismatch("out_group", e.grp, rsp_out_group);
            if (rsp_accumulated_score !== e.score)
               report_mismatch("accumulated_score", e.score, rsp_accumulated_score);
            if (rsp_last !== e.last) report_mismatch("last", e.last, rsp_last);
         end
      end
   end

   initial begin
      #50ms;
      $display("Simulation FAILED");
      $finish;
   end

   word_type directed [$];

   function automatic word_type mk(kind_type k, logic [5:0] g, logic [31:0] x, logic [31:0] m,
                                   logic [30:0] p, logic [31:0] b, logic [31:0] c,
                                   bit typed = 0, logic [31:0] want = '0);
      word_type w;
      w.kind = k; w.grp = g; w.sample = x; w.mean = m; w.prec = p;
      w.base = b; w.coeff = c; w.typed = typed; w.want = want;
      return w;
   endfunction

   initial begin
      int cfgs [6] = '{1, 64, 127, 0, 7, 33};
      int modes [4] = '{0, 79, 0, 32};
      int rsp_modes [4] = '{0, 0, 79, 32};
      int count, n, missing, r;
      word_type w;

      for (int k = 0; k < 256; k++) log2_frac[k] = frac_log2_entry(k);
      foreach (g_acc[i]) begin
         g_acc[i] = '0; g_loaded[i] = 0;
         g_mean[i] = '0; g_prec[i] = '0; g_base[i] = '0; g_coeff[i] = '0;
      end
      n_active = 7'd1;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      directed.push_back(mk(KIND_LOAD, 0, 0, 0, 0, 0, 0));
      directed.push_back(mk(KIND_SCORE, 0, 0, 0, 0, 0, 0, 1, 32'd0));
      directed.push_back(mk(KIND_LOAD, 0, 0, 0, 0, 32'h7FFF_FFFF, 0));
      directed.push_back(mk(KIND_SCORE, 0, 32'h1234, 0, 0, 0, 0, 1, 32'h7FFF_FFFF));
      directed.push_back(mk(KIND_SCORE, 0, 32'h8000_0000, 0, 0, 0, 0, 1, 32'h7FFF_FFFF));
      directed.push_back(mk(KIND_CLEAR, 0, 0, 0, 0, 0, 0));
      directed.push_back(mk(KIND_LOAD, 0, 0, 0, 0, 32'h8000_0000, 0));
      directed.push_back(mk(KIND_SCORE, 0, 32'h7FFF_FFFF, 0, 0, 0, 0, 1, 32'h8000_0000));
      directed.push_back(mk(KIND_CLEAR, 0, 0, 0, 0, 0, 0));
      directed.push_back(mk(KIND_LOAD, 0, 0, 32'h8000_0000, 31'h7FFF_FFFF, 0, 32'h7FFF_FFFF));
      directed.push_back(mk(KIND_SCORE, 0, 32'h7FFF_FFFF, 0, 0, 0, 0));
      directed.push_back(mk(KIND_SCORE, 0, 32'h8000_0000, 0, 0, 0, 0));
      directed.push_back(mk(KIND_LOAD, 0, 0, 32'h12345, 31'h10000, 32'hFFFF_FFFF,
                            32'h8000_0000));
      directed.push_back(mk(KIND_SCORE, 0, 32'h7FFF_FFFF, 0, 0, 0, 0));
      directed.push_back(mk(KIND_SCORE, 0, 32'h0001_8000, 0, 0, 0, 0));
      directed.push_back(mk(KIND_NONE, 6'h3F, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF,
                            32'hFFFF_FFFF, 32'hFFFF_FFFF));
      directed.push_back(mk(KIND_LOAD, 6'h3F, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF,
                            32'hFFFF_FFFF, 32'hFFFF_FFFF));
      directed.push_back(mk(KIND_SCORE, 0, 32'hFFFF_FFFF, 0, 0, 0, 0));
      directed.push_back(mk(KIND_LOAD, 0, 0, 32'h7FFF_FFFF, 31'h1, 32'h100, 32'h10000));
      directed.push_back(mk(KIND_SCORE, 0, 32'h8000_0000, 0, 0, 0, 0));
      foreach (directed[i]) send_word(directed[i]);
      req_valid <= 1'b0;
      drain();

      for (int ph = 0; ph < 6; ph++) begin
         write_csr(7'(cfgs[ph]));
         idle_pct = modes[ph % 4];
         stall_pct <= rsp_modes[ph % 4];
         if (ph == 1) hold_req <= 1'b1;
         n = (n_active > 64) ? 64 : n_active;
         count = 0;
         while (count < 74) begin
            w = mk(KIND_SCORE, 6'($urandom), pick_value(), pick_value(), 31'(pick_value()),
                   pick_value(), pick_value());
            r = $urandom_range(99);
            missing = -1;
            for (int i = n - 1; i >= 0; i--) if (!g_loaded[i]) missing = i;
            if (missing >= 0) begin
               w.kind = KIND_LOAD;
               w.grp = 6'(missing);
            end else if (r < 15) w.kind = KIND_LOAD;
            else if (r < 20) w.kind = KIND_CLEAR;
            else if (r < 24) w.kind = KIND_NONE;
            if (w.kind != KIND_NONE) count++;
            send_word(w);
         end
         req_valid <= 1'b0;
         drain();
      end

      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
